// File: design/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

  // CORDIC rotation steps, 12 to 31
  localparam int unsigned CORDIC_STEPS = 24;
  // step counter covers the full arctangent table
  localparam int unsigned STEP_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [31:0] CORDIC_GAIN  = 32'h26DD3B6A;
  localparam logic [31:0] QUARTER_TURN = 32'h40000000;
  localparam logic [31:0] HALF_TURN    = 32'h80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_SCALE    = 2'd0,
    CFG_HEADING_SCALE = 2'd1,
    CFG_WHEEL_SCALE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        heading;
    logic [31:0]        left_wheel_angle;
    logic [31:0]        right_wheel_angle;
  } out_item_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: design/ddo_if.sv
`timescale 1ns / 1ps

// encoder count channel
interface ddo_in_if;
  logic              valid;
  logic              ready;
  ddo_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// pose result channel
interface ddo_out_if;
  logic               valid;
  logic               ready;
  ddo_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/diff_drive_encoder_odometry_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake       Payload
// in_i      in   valid / ready   left_count, right_count
// out_o     out  valid / ready   pose_x, pose_y, heading, left/right_wheel_angle
// cfg       in   cfg_we_i        cfg_idx_i selects scale register, cfg_data_i
//
// Each item is worked on in turn: accept in idle, the multiplies for the two
// wheel angles, the heading and the distance, one CORDIC set-up, CORDIC_STEPS
// rotations, the pose products, then the load of the output register. The single
// 33x33 multiplier and the CORDIC rotation loop make the work serial, and a new
// item is not taken until the result of the last one has been loaded.
// Reset clears all pose, angle and count state and the scale registers.
// A waiting result holds the sequencer in its final load; the output register
// lets the next item be taken and worked on while the result waits.

module diff_drive_encoder_odometry_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_data_i,
  ddo_in_if.sink                       in_i,
  ddo_out_if.source                    out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MWL, S_MWR, S_MHD, S_MDS, S_CINIT, S_ROT,
    S_PX0, S_PX1, S_PX2, S_PX3, S_PX4, S_PX5, S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [31:0] dist_scale_q, heading_scale_q, wheel_scale_q;

  logic [31:0] last_left_q, last_left_d, last_right_q, last_right_d;
  logic [31:0] dlu_q, dlu_d, dru_q, dru_d;
  logic [47:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [31:0] heading_q, heading_d, lang_q, lang_d, rang_q, rang_d;
  logic [31:0] dh_q, dh_d;
  logic [47:0] dist_q, dist_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [32:0] cz_q, cz_d;
  logic        flip_q, flip_d;
  logic [ddo_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [77:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  ddo_pkg::out_item_t out_data_q, out_data_d;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  logic        in_acc;
  logic [32:0] sum_lr;
  logic [31:0] ang, ang_q1, ang_rot;
  logic signed [31:0] xs, ys, xn, yn;
  logic signed [32:0] zn, at;
  logic [77:0] prod_lo, prod_hi;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // scale registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_scale_q    <= '0;
      heading_scale_q <= '0;
      wheel_scale_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ddo_pkg::CFG_DIST_SCALE:    dist_scale_q    <= cfg_data_i;
        ddo_pkg::CFG_HEADING_SCALE: heading_scale_q <= cfg_data_i;
        ddo_pkg::CFG_WHEEL_SCALE:   wheel_scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand select for the multiplier
  assign sum_lr = {dlu_q[31], dlu_q} + {dru_q[31], dru_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MWL: begin
        mul_a = {1'b0, dlu_q};
        mul_b = {1'b0, wheel_scale_q};
      end
      S_MWR: begin
        mul_a = {1'b0, dru_q};
        mul_b = {1'b0, wheel_scale_q};
      end
      S_MHD: begin
        mul_a = {1'b0, dru_q - dlu_q};
        mul_b = {1'b0, heading_scale_q};
      end
      S_MDS: begin
        mul_a = {1'b0, sum_lr[31:0]};
        mul_b = {1'b0, dist_scale_q};
      end
      S_PX0: begin
        mul_a = {9'b0, dist_q[23:0]};
        mul_b = {cx_q[31], cx_q};
      end
      S_PX1: begin
        mul_a = {{9{dist_q[47]}}, dist_q[47:24]};
        mul_b = {cx_q[31], cx_q};
      end
      S_PX2: begin
        mul_a = {9'b0, dist_q[23:0]};
        mul_b = {cy_q[31], cy_q};
      end
      S_PX3: begin
        mul_a = {{9{dist_q[47]}}, dist_q[47:24]};
        mul_b = {cy_q[31], cy_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // low and high partial products of the 48 by 32 pose product
  assign prod_lo = {{12{mul_q[65]}}, mul_q};
  assign prod_hi = {mul_q[53:0], 24'b0};

  // midpoint heading and half-turn fold for CORDIC
  assign ang     = heading_q + {dh_q[31], dh_q[31:1]};
  assign ang_q1  = ang + ddo_pkg::QUARTER_TURN;
  assign ang_rot = ang_q1[31] ? (ang - ddo_pkg::HALF_TURN) : ang;

  // one rotation step
  assign xs = cx_q >>> cnt_q;
  assign ys = cy_q >>> cnt_q;
  assign at = {1'b0, ddo_pkg::atan_lut(cnt_q)};

  always_comb begin
    if (!cz_q[32]) begin
      xn = cx_q - ys;
      yn = cy_q + xs;
      zn = cz_q - at;
    end else begin
      xn = cx_q + ys;
      yn = cy_q - xs;
      zn = cz_q + at;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    last_left_d  = last_left_q;
    last_right_d = last_right_q;
    dlu_d        = dlu_q;
    dru_d        = dru_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    heading_d    = heading_q;
    lang_d       = lang_q;
    rang_d       = rang_q;
    dh_d         = dh_q;
    dist_d       = dist_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    cz_d         = cz_q;
    flip_d       = flip_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_data_d   = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dlu_d        = in_i.data.left_count - last_left_q;
          dru_d        = in_i.data.right_count - last_right_q;
          last_left_d  = in_i.data.left_count;
          last_right_d = in_i.data.right_count;
          state_d      = S_MWL;
        end
      end
      S_MWL: state_d = S_MWR;
      S_MWR: begin
        lang_d  = lang_q + mul_q[31:0];
        state_d = S_MHD;
      end
      S_MHD: begin
        rang_d  = rang_q + mul_q[31:0];
        state_d = S_MDS;
      end
      S_MDS: begin
        dh_d    = mul_q[31:0];
        state_d = S_CINIT;
      end
      S_CINIT: begin
        // sign of the 33-bit sum folds in as minus scale times 2^32
        dist_d    = mul_q[47:0] - (sum_lr[32] ? {dist_scale_q[15:0], 32'b0} : 48'b0);
        flip_d    = ang_q1[31];
        cz_d      = {ang_rot[31], ang_rot};
        cx_d      = ddo_pkg::CORDIC_GAIN;
        cy_d      = '0;
        cnt_d     = '0;
        heading_d = heading_q + dh_q;
        state_d   = S_ROT;
      end
      S_ROT: begin
        cz_d = zn;
        if (cnt_q == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
          cx_d    = flip_q ? -xn : xn;
          cy_d    = flip_q ? -yn : yn;
          state_d = S_PX0;
        end else begin
          cx_d  = xn;
          cy_d  = yn;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_PX0: state_d = S_PX1;
      S_PX1: begin
        acc_d   = prod_lo;
        state_d = S_PX2;
      end
      S_PX2: begin
        acc_d   = acc_q + prod_hi;
        state_d = S_PX3;
      end
      S_PX3: begin
        pos_x_d = pos_x_q + acc_q[77:30];
        acc_d   = prod_lo;
        state_d = S_PX4;
      end
      S_PX4: begin
        acc_d   = acc_q + prod_hi;
        state_d = S_PX5;
      end
      S_PX5: begin
        pos_y_d = pos_y_q + acc_q[77:30];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                  = 1'b1;
          out_data_d.pose_x            = pos_x_q[47:16];
          out_data_d.pose_y            = pos_y_q[47:16];
          out_data_d.heading           = heading_q;
          out_data_d.left_wheel_angle  = lang_q;
          out_data_d.right_wheel_angle = rang_q;
          state_d                      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      last_left_q  <= '0;
      last_right_q <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      heading_q    <= '0;
      lang_q       <= '0;
      rang_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      last_left_q  <= last_left_d;
      last_right_q <= last_right_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      heading_q    <= heading_d;
      lang_q       <= lang_d;
      rang_q       <= rang_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    dlu_q      <= dlu_d;
    dru_q      <= dru_d;
    dh_q       <= dh_d;
    dist_q     <= dist_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    flip_q     <= flip_d;
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input taken again while an item is in flight");

  a_last_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (last_left_q == $past(in_i.data.left_count)) &&
               (last_right_q == $past(in_i.data.right_count)))
    else $error("previous counts not updated from the accepted item");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (cnt_q < ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS)))
    else $error("rotation step counter ran past the step count");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || out_o.ready)) |=> out_valid_q && in_i.ready)
    else $error("result not presented after the pose update");

endmodule
